FILE: hdl/bicubic_bezier_patch_eval_top_assert.svh
// Assertion macros shared by the bicubic Bezier patch evaluator RTL.
`ifndef BICUBIC_BEZIER_PATCH_EVAL_TOP_ASSERT_SVH
`define BICUBIC_BEZIER_PATCH_EVAL_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, clocked on clk, off during reset.
`define BBPE_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bbpe assertion failed");
// Next-cycle implication, clocked on clk, off during reset.
`define BBPE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bbpe assertion failed");
`else
`define BBPE_ASSERT_IMPL(label, ante, cons)
`define BBPE_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/bbpe_pkg.sv
// Shared constants and controller/datapath interface types for the patch evaluator.
`default_nettype none
package bbpe_pkg;

	localparam int COORD_WIDTH_DEF     = 32;
	localparam int PARAM_FRAC_BITS_DEF = 16;

	localparam int CTL_POINTS = 16;
	localparam int IDX_W      = 4;
	localparam int CNT_W      = 5;

	// counts 0..15 feed the points; the counter then runs on to CNT_LAST while the MAC pipeline drains
	localparam logic [CNT_W-1:0] CNT_FEED_END = 5'd16;
	localparam logic [CNT_W-1:0] CNT_LAST     = 5'd17;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_EVAL = 1'b1;

	typedef struct packed {
		logic             load;
		logic             start;
		logic             prep1;
		logic             prep2;
		logic             feed;
		logic [IDX_W-1:0] idx;
		logic             write_out;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_sts_t;

endpackage
`default_nettype wire

FILE: hdl/bbpe_ctrl.sv
// Controller state machine sequencing loads and evaluations of the patch.
`default_nettype none
`include "bicubic_bezier_patch_eval_top_assert.svh"
module bbpe_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              req_type,
	input  wire bbpe_pkg::dp_sts_t sts,
	output bbpe_pkg::dp_cmd_t      cmd
);
	import bbpe_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PREP1 = 3'd1;
	localparam logic [2:0] S_PREP2 = 3'd2;
	localparam logic [2:0] S_EVAL  = 3'd3;
	localparam logic [2:0] S_WRITE = 3'd4;

	logic [2:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             acc_in;

	assign in_ready = (state_q == S_IDLE);
	assign acc_in   = in_valid && in_ready;

	always_comb begin
		cmd.load      = acc_in && (req_type == REQ_LOAD);
		cmd.start     = acc_in && (req_type == REQ_EVAL);
		cmd.prep1     = (state_q == S_PREP1);
		cmd.prep2     = (state_q == S_PREP2);
		cmd.feed      = (state_q == S_EVAL) && (cnt_q < CNT_FEED_END);
		cmd.idx       = cnt_q[IDX_W-1:0];
		cmd.write_out = (state_q == S_WRITE) && !sts.out_busy;
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.start) begin
					state_d = S_PREP1;
				end
			end
			S_PREP1: begin
				state_d = S_PREP2;
			end
			S_PREP2: begin
				state_d = S_EVAL;
				cnt_d   = '0;
			end
			S_EVAL: begin
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_LAST) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE: begin
				if (!sts.out_busy) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	`BBPE_ASSERT_NEXT(a_eval_start, cmd.start, state_q == S_PREP1)
	`BBPE_ASSERT_NEXT(a_cnt_step, state_q == S_EVAL && cnt_q != CNT_LAST, state_q == S_EVAL && cnt_q == $past(cnt_q) + CNT_W'(1))
	`BBPE_ASSERT_NEXT(a_eval_len, state_q == S_EVAL && cnt_q == CNT_LAST, state_q == S_WRITE)

endmodule
`default_nettype wire

FILE: hdl/bbpe_datapath.sv
// Datapath: control point stores, Bernstein weights and per-coordinate MAC lanes.
`default_nettype none
module bbpe_datapath #(
	parameter int COORD_WIDTH     = bbpe_pkg::COORD_WIDTH_DEF,
	parameter int PARAM_FRAC_BITS = bbpe_pkg::PARAM_FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bbpe_pkg::dp_cmd_t             cmd,
	output bbpe_pkg::dp_sts_t                  sts,
	input  wire logic [bbpe_pkg::IDX_W-1:0]    point_index,
	input  wire logic signed [COORD_WIDTH-1:0] point_x,
	input  wire logic signed [COORD_WIDTH-1:0] point_y,
	input  wire logic signed [COORD_WIDTH-1:0] point_z,
	input  wire logic [PARAM_FRAC_BITS:0]      u_param,
	input  wire logic [PARAM_FRAC_BITS:0]      v_param,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0]      out_x,
	output logic signed [COORD_WIDTH-1:0]      out_y,
	output logic signed [COORD_WIDTH-1:0]      out_z
);
	import bbpe_pkg::*;

	localparam int CW    = COORD_WIDTH;
	localparam int F     = PARAM_FRAC_BITS;
	localparam int PW    = F + 1;
	localparam int TW    = F + 3;
	localparam int PRD_W = 2 * F + 4;
	localparam int MUL_W = CW + PW + 1;
	localparam int TRM_W = CW + 1;
	localparam int ACC_W = CW + 5;

	localparam logic [PW-1:0]    ONE_P  = {1'b1, {F{1'b0}}};
	localparam logic [PRD_W-1:0] HALF_W = PRD_W'(1) << (F - 1);
	localparam logic [MUL_W-1:0] HALF_M = MUL_W'(1) << (F - 1);

	function automatic logic [PW-1:0] rnd_w(input logic [PRD_W-1:0] p);
		logic [PRD_W-1:0] s;
		s = p + HALF_W;
		return s[F +: PW];
	endfunction

	function automatic logic [CW-1:0] sat(input logic [ACC_W-1:0] a);
		logic [CW-1:0] r;
		if ((&a[ACC_W-1:CW-1]) || !(|a[ACC_W-1:CW-1])) begin
			r = a[CW-1:0];
		end else if (a[ACC_W-1]) begin
			r = {1'b1, {(CW-1){1'b0}}};
		end else begin
			r = {1'b0, {(CW-1){1'b1}}};
		end
		return r;
	endfunction

	// axis 0 is u (rows), axis 1 is v (columns)
	logic [PW-1:0] clamp [2];
	logic [PW-1:0] a_q [2];
	logic [PW-1:0] b_q [2];
	logic [TW-1:0] a3_q [2];
	logic [TW-1:0] b3_q [2];
	logic [PW-1:0] a2_q [2];
	logic [PW-1:0] b2_q [2];
	logic [PW-1:0] wt_q [2][4];

	assign clamp[0] = (u_param > ONE_P) ? ONE_P : u_param;
	assign clamp[1] = (v_param > ONE_P) ? ONE_P : v_param;

	always_ff @(posedge clk) begin
		for (int d = 0; d < 2; d++) begin
			if (cmd.start) begin
				a_q[d]  <= clamp[d];
				b_q[d]  <= ONE_P - clamp[d];
				a3_q[d] <= TW'(clamp[d]) + TW'({clamp[d], 1'b0});
				b3_q[d] <= TW'(ONE_P - clamp[d]) + TW'({ONE_P - clamp[d], 1'b0});
			end
			if (cmd.prep1) begin
				a2_q[d] <= rnd_w(PRD_W'(a_q[d]) * PRD_W'(a_q[d]));
				b2_q[d] <= rnd_w(PRD_W'(b_q[d]) * PRD_W'(b_q[d]));
			end
			if (cmd.prep2) begin
				wt_q[d][0] <= rnd_w(PRD_W'(a2_q[d]) * PRD_W'(a_q[d]));
				wt_q[d][1] <= rnd_w(PRD_W'(a2_q[d]) * PRD_W'(b3_q[d]));
				wt_q[d][2] <= rnd_w(PRD_W'(a3_q[d]) * PRD_W'(b2_q[d]));
				wt_q[d][3] <= rnd_w(PRD_W'(b2_q[d]) * PRD_W'(b_q[d]));
			end
		end
	end

	// point weight, formed in the same cycle the point is read
	logic [PW-1:0] w_s1;
	logic          v_s1, v_s2;
	logic          out_valid_q;

	always_ff @(posedge clk) begin
		if (cmd.feed) begin
			w_s1 <= rnd_w(PRD_W'(wt_q[0][cmd.idx[IDX_W-1:2]]) * PRD_W'(wt_q[1][cmd.idx[1:0]]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s1 <= cmd.feed;
			v_s2 <= v_s1;
			if (cmd.write_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	logic signed [CW-1:0] pin [3];
	logic [CW-1:0]        out_q [3];

	assign pin[0] = point_x;
	assign pin[1] = point_y;
	assign pin[2] = point_z;

	for (genvar c = 0; c < 3; c++) begin : g_lane
		logic signed [CW-1:0]    st_q [CTL_POINTS];
		logic signed [CW-1:0]    p_s1;
		logic signed [MUL_W-1:0] prod;
		logic [MUL_W-1:0]        rsum;
		logic [TRM_W-1:0]        trm;
		logic [TRM_W-1:0]        t_s2;
		logic [ACC_W-1:0]        acc_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int k = 0; k < CTL_POINTS; k++) begin
					st_q[k] <= '0;
				end
			end else if (cmd.load) begin
				st_q[point_index] <= pin[c];
			end
		end

		// exact round-half-up of point times weight
		assign prod = p_s1 * $signed({1'b0, w_s1});
		assign rsum = prod + $signed(HALF_M);
		assign trm  = rsum[F +: TRM_W];

		always_ff @(posedge clk) begin
			if (cmd.feed) begin
				p_s1 <= st_q[cmd.idx];
			end
			if (v_s1) begin
				t_s2 <= trm;
			end
			if (cmd.start) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + {{(ACC_W-TRM_W){t_s2[TRM_W-1]}}, t_s2};
			end
			if (cmd.write_out) begin
				out_q[c] <= sat(acc_q);
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_x        = $signed(out_q[0]);
	assign out_y        = $signed(out_q[1]);
	assign out_z        = $signed(out_q[2]);

endmodule
`default_nettype wire

FILE: hdl/bicubic_bezier_patch_eval_top.sv
// Top level of the bicubic Bezier patch evaluator: controller plus datapath.
//
// channel | handshake           | payload
// in      | in_valid, in_ready   | req_type, point_index, point_x/y/z, u_param, v_param
// out     | out_valid, out_ready | out_x, out_y, out_z
//
// A load item writes its control point as it is accepted; the input stays ready.
// An evaluate item holds the input off until its output write. After the accept
// come the weight steps PREP1 and PREP2, the walk over the 16 points through one
// MAC lane per coordinate, the MAC pipeline drain and the output write, which
// registers the result. Reset clears all control points to zero; items are taken
// right after reset. A finished result waits in the output register; only the
// output write of the following evaluation stalls while it is still untaken.
`default_nettype none
module bicubic_bezier_patch_eval_top #(
	parameter int COORD_WIDTH     = bbpe_pkg::COORD_WIDTH_DEF,
	parameter int PARAM_FRAC_BITS = bbpe_pkg::PARAM_FRAC_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          req_type,
	input  wire logic [bbpe_pkg::IDX_W-1:0]    point_index,
	input  wire logic signed [COORD_WIDTH-1:0] point_x,
	input  wire logic signed [COORD_WIDTH-1:0] point_y,
	input  wire logic signed [COORD_WIDTH-1:0] point_z,
	input  wire logic [PARAM_FRAC_BITS:0]      u_param,
	input  wire logic [PARAM_FRAC_BITS:0]      v_param,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0]      out_x,
	output logic signed [COORD_WIDTH-1:0]      out_y,
	output logic signed [COORD_WIDTH-1:0]      out_z
);
	import bbpe_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	bbpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	bbpe_datapath #(
		.COORD_WIDTH     (COORD_WIDTH),
		.PARAM_FRAC_BITS (PARAM_FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.point_index (point_index),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.u_param     (u_param),
		.v_param     (v_param),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_x       (out_x),
		.out_y       (out_y),
		.out_z       (out_z)
	);

endmodule
`default_nettype wire

FILE: verif/bbpe_tb_pkg.sv
// Surface predictor and result scoreboard for the bicubic Bezier patch evaluator bench.
package bbpe_tb_pkg;
	import bbpe_pkg::*;

	localparam int CW = COORD_WIDTH_DEF;
	localparam int FB = PARAM_FRAC_BITS_DEF;
	localparam longint UNIT = longint'(1) << FB;
	localparam longint HALF_UNIT = longint'(1) << (FB - 1);

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [FB:0] param_t;
	typedef logic [IDX_W-1:0] index_t;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
	} surface_point_t;

	class patch_scoreboard;
		coord_t ctl_x[CTL_POINTS];
		coord_t ctl_y[CTL_POINTS];
		coord_t ctl_z[CTL_POINTS];
		surface_point_t pending_points[$];
		int mismatch_count;

		function new();
			for (int k = 0; k < CTL_POINTS; k++) begin
				ctl_x[k] = '0;
				ctl_y[k] = '0;
				ctl_z[k] = '0;
			end
			mismatch_count = 0;
		endfunction

		// floor((p + half) / unit); arithmetic shift keeps negative terms exact
		function longint round_q(longint p);
			return (p + HALF_UNIT) >>> FB;
		endfunction

		function void bernstein(input longint t, output longint w[4]);
			longint a, b, a2, b2;
			a = (t > UNIT) ? UNIT : t;
			b = UNIT - a;
			a2 = round_q(a * a);
			b2 = round_q(b * b);
			w[0] = round_q(a2 * a);
			w[1] = round_q(3 * a2 * b);
			w[2] = round_q(3 * a * b2);
			w[3] = round_q(b2 * b);
		endfunction

		function coord_t saturate(longint s);
			longint hi, lo;
			hi = (longint'(1) <<< (CW - 1)) - 1;
			lo = -hi - 1;
			if (s > hi)
				s = hi;
			if (s < lo)
				s = lo;
			return s[CW-1:0];
		endfunction

		function surface_point_t eval_surface(param_t u, param_t v);
			longint wu[4], wv[4];
			longint w, sx, sy, sz;
			int k;
			surface_point_t r;
			bernstein(longint'(u), wu);
			bernstein(longint'(v), wv);
			sx = 0;
			sy = 0;
			sz = 0;
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					k = 4 * i + j;
					w = round_q(wu[i] * wv[j]);
					sx += round_q(longint'(ctl_x[k]) * w);
					sy += round_q(longint'(ctl_y[k]) * w);
					sz += round_q(longint'(ctl_z[k]) * w);
				end
			end
			r.x = saturate(sx);
			r.y = saturate(sy);
			r.z = saturate(sz);
			return r;
		endfunction

		function void note_item(logic req, index_t idx, coord_t px, coord_t py, coord_t pz,
				param_t u, param_t v);
			if (req == REQ_LOAD) begin
				ctl_x[idx] = px;
				ctl_y[idx] = py;
				ctl_z[idx] = pz;
			end else begin
				pending_points.push_back(eval_surface(u, v));
			end
		endfunction

		function int pending();
			return pending_points.size();
		endfunction

		task report(string what);
			$display("MISMATCH: %s", what);
			mismatch_count++;
		endtask

		task compare_coord(string name, coord_t got, coord_t want);
			if (got !== want)
				report($sformatf("%s got %0d (0x%h) expected %0d (0x%h)",
					name, got, got, want, want));
		endtask

		task check_result(coord_t x, coord_t y, coord_t z);
			surface_point_t want;
			if (pending_points.size() == 0) begin
				report($sformatf("surface point (%0d, %0d, %0d) with no evaluation pending",
					x, y, z));
				return;
			end
			want = pending_points.pop_front();
			compare_coord("out_x", x, want.x);
			compare_coord("out_y", y, want.y);
			compare_coord("out_z", z, want.z);
		endtask

		task flag_leftovers();
			if (pending_points.size() != 0)
				report($sformatf("%0d evaluations never produced a surface point",
					pending_points.size()));
		endtask
	endclass

endpackage

FILE: verif/tb_bicubic_bezier_patch_eval_top.sv
// Testbench top: drives load and evaluate items and checks surface points against a predictor.
module tb_bicubic_bezier_patch_eval_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bbpe_pkg::*;
	import bbpe_tb_pkg::*;

	localparam int RANDOM_ITEMS = 450;
	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLDOFF_CYCLES = 200;
	localparam int SETTLE_CYCLES = 40;

	localparam param_t ONE_Q = param_t'(UNIT);
	localparam coord_t C_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam coord_t C_MIN = {1'b1, {(CW-1){1'b0}}};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic req_type;
	index_t point_index;
	coord_t point_x;
	coord_t point_y;
	coord_t point_z;
	param_t u_param;
	param_t v_param;
	logic out_valid;
	logic out_ready;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;

	patch_scoreboard sb = new();
	int item_count = 0;
	int cycle_count = 0;
	bit no_idle = 1'b0;
	bit holdoff_req = 1'b0;

	bicubic_bezier_patch_eval_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.point_index(point_index),
		.point_x(point_x),
		.point_y(point_y),
		.point_z(point_z),
		.u_param(u_param),
		.v_param(v_param),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_x(out_x),
		.out_y(out_y),
		.out_z(out_z)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_x, out_y, out_z);
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_req) begin
				out_ready = 1'b0;
				repeat (HOLDOFF_CYCLES) @(negedge clk);
				holdoff_req = 1'b0;
			end
			out_ready = no_idle || ($urandom_range(99) >= 28);
		end
	end

	function automatic coord_t rand_coord();
		int pick;
		pick = $urandom_range(99);
		if (pick < 25)
			return coord_t'($urandom);
		else if (pick < 50)
			return coord_t'($signed($urandom_range(2097152)) - 1048576);
		else if (pick < 70) begin
			case ($urandom_range(4))
				0: return C_MAX;
				1: return C_MIN;
				2: return '0;
				3: return coord_t'(-1);
				default: return coord_t'(1);
			endcase
		end
		return coord_t'($signed($urandom) >>> 8);
	endfunction

	function automatic param_t rand_param();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return '0;
		else if (pick < 20)
			return ONE_Q;
		else if (pick < 30)
			return param_t'($urandom_range(131071, 65537));
		else if (pick < 40)
			return param_t'($urandom_range(131071));
		return param_t'($urandom_range(65536));
	endfunction

	task automatic maybe_idle();
		int n;
		if (!no_idle && $urandom_range(99) < 28) begin
			n = $urandom_range(1, 6);
			repeat (n) begin
				@(negedge clk);
				in_valid = 1'b0;
			end
		end
	endtask

	task automatic send_item(logic req, index_t idx, coord_t x, coord_t y, coord_t z,
			param_t u, param_t v);
		maybe_idle();
		@(negedge clk);
		in_valid = 1'b1;
		req_type = req;
		point_index = idx;
		point_x = x;
		point_y = y;
		point_z = z;
		u_param = u;
		v_param = v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_item(req, idx, x, y, z, u, v);
		item_count++;
	endtask

	// parameters carry junk on a load, as do point fields on an evaluate
	task automatic load_point(index_t idx, coord_t x, coord_t y, coord_t z);
		send_item(REQ_LOAD, idx, x, y, z, param_t'($urandom), param_t'($urandom));
	endtask

	task automatic eval_at(param_t u, param_t v);
		send_item(REQ_EVAL, index_t'($urandom), coord_t'($urandom), coord_t'($urandom),
			coord_t'($urandom), u, v);
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		int pick, n, rand_start, progress;
		bit holdoff_done, pause_done;
		coord_t fill;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_LOAD;
		point_index = '0;
		point_x = '0;
		point_y = '0;
		point_z = '0;
		u_param = '0;
		v_param = '0;
		holdoff_done = 1'b0;
		pause_done = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// untouched patch reads as zero, including clamped parameters
		eval_at('0, '0);
		eval_at(param_t'(70000), param_t'(131071));
		load_point(index_t'(0), C_MAX, C_MIN, '0);
		load_point(index_t'(3), C_MIN, C_MAX, coord_t'(-1));
		load_point(index_t'(12), coord_t'(1), coord_t'(-1), C_MAX);
		load_point(index_t'(15), coord_t'(-65536), coord_t'(65536), C_MIN);
		// corners pick out single control points
		eval_at(ONE_Q, ONE_Q);
		eval_at(ONE_Q, '0);
		eval_at('0, ONE_Q);
		eval_at('0, '0);
		eval_at('1, '1);
		eval_at(ONE_Q >> 1, ONE_Q >> 1);
		load_point(index_t'(5), C_MAX, C_MAX, C_MIN);
		load_point(index_t'(6), C_MAX, C_MAX, C_MIN);
		load_point(index_t'(9), C_MAX, C_MAX, C_MIN);
		load_point(index_t'(10), C_MAX, C_MAX, C_MIN);
		eval_at(ONE_Q >> 1, ONE_Q >> 1);
		eval_at(param_t'(1), param_t'(65535));
		eval_at(param_t'(65535), param_t'(1));
		eval_at(param_t'(21845), param_t'(43691));
		wait_results_drained();

		rand_start = item_count;
		progress = 0;
		while (progress < RANDOM_ITEMS) begin
			no_idle = (progress >= 220) && (progress < 300);
			if (!holdoff_done && progress >= 120) begin
				// receiver stalls long enough for the input to back up
				holdoff_done = 1'b1;
				holdoff_req = 1'b1;
				repeat (8) eval_at(rand_param(), rand_param());
			end else if (!pause_done && progress >= 330) begin
				pause_done = 1'b1;
				wait_results_drained();
			end
			pick = $urandom_range(99);
			if (pick < 45) begin
				n = $urandom_range(1, 16);
				repeat (n)
					load_point(index_t'($urandom), rand_coord(), rand_coord(), rand_coord());
				n = $urandom_range(1, 3);
				repeat (n) eval_at(rand_param(), rand_param());
			end else if (pick < 55) begin
				// whole patch near full scale: rounding of weights may push past range
				for (int k = 0; k < CTL_POINTS; k++) begin
					fill = coord_t'($urandom_range(255));
					load_point(index_t'(k), C_MAX - fill, C_MIN + fill,
						(k % 2 == 1) ? C_MAX : C_MIN);
				end
				repeat (2) eval_at(rand_param(), rand_param());
			end else if (pick < 88) begin
				n = $urandom_range(1, 4);
				repeat (n) eval_at(rand_param(), rand_param());
			end else begin
				send_item(1'($urandom), index_t'($urandom), coord_t'($urandom),
					coord_t'($urandom), coord_t'($urandom), param_t'($urandom),
					param_t'($urandom));
			end
			progress = item_count - rand_start;
		end
		no_idle = 1'b0;

		wait_results_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.flag_leftovers();
		if (sb.mismatch_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

FILE: bicubic_bezier_patch_eval_top.f
+incdir+hdl
hdl/bbpe_pkg.sv
hdl/bbpe_ctrl.sv
hdl/bbpe_datapath.sv
hdl/bicubic_bezier_patch_eval_top.sv
verif/bbpe_tb_pkg.sv
verif/tb_bicubic_bezier_patch_eval_top.sv
